// File: rtl/core/mrms_pkg.sv
package mrms_pkg;

   // register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_SCALE_NUM = 1'b0,
      CSR_SCALE_DEN = 1'b1
   } csr_index_type;

   localparam int DELTA_W  = 8;
   localparam int SCALE_W  = 8;
   localparam int ACC_W    = 17;   // remainder + delta * num
   localparam int MAG_W    = 16;   // |sum| always fits here
   localparam int REM_W    = 9;
   localparam int PEND_W   = 24;
   localparam int POS_W    = 7;
   localparam int JOY_W    = 5;
   localparam int BTN_W    = 8;

   localparam int MUL_STEPS = SCALE_W;
   localparam int DIV_STEPS = MAG_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [JOY_W-1:0] JOY_IDLE   = 5'h1F;
   localparam logic [JOY_W-1:0] JOY_LEFT   = 5'h10;
   localparam logic [JOY_W-1:0] JOY_RIGHT  = 5'h01;
   localparam logic [JOY_W-1:0] JOY_MIDDLE = 5'h02;

   localparam logic signed [PEND_W-1:0] DRAIN_HI = 24'sd50;
   localparam logic signed [PEND_W-1:0] DRAIN_LO = -24'sd50;
   localparam logic signed [POS_W-1:0]  DRAIN_POS = 7'sd50;
   localparam logic signed [POS_W-1:0]  DRAIN_NEG = -7'sd50;

   localparam logic signed [PEND_W-1:0] PEND_MAX = 24'sh7FFFFF;
   localparam logic signed [PEND_W-1:0] PEND_MIN = 24'sh800000;

endpackage

// File: rtl/core/mrms_axis.sv
// One motion axis: serial multiply, restoring divide, pending sum, drain.
module mrms_axis (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  negate,
   input  logic signed [mrms_pkg::DELTA_W-1:0]   delta,
   input  logic        [mrms_pkg::SCALE_W-1:0]   scale_num,
   input  logic        [mrms_pkg::SCALE_W-1:0]   scale_den,
   output logic                                  done,
   output logic        [mrms_pkg::POS_W-1:0]     position
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ABS,
      ST_DIV,
      ST_SIGN,
      ST_PEND,
      ST_DRAIN
   } state_type;

   state_type                               state_ff;
   logic        [mrms_pkg::CNT_W-1:0]       cnt_ff;
   logic signed [mrms_pkg::ACC_W-1:0]       acc_ff;
   logic signed [mrms_pkg::ACC_W-1:0]       mcand_ff;
   logic        [mrms_pkg::SCALE_W-1:0]     mult_ff;
   logic        [mrms_pkg::SCALE_W-1:0]     den_ff;
   logic        [mrms_pkg::MAG_W-1:0]       quo_ff;
   logic        [mrms_pkg::SCALE_W-1:0]     prem_ff;
   logic                                    sign_ff;
   logic signed [mrms_pkg::ACC_W-1:0]       q_ff;
   logic signed [mrms_pkg::REM_W-1:0]       rem_ff;
   logic signed [mrms_pkg::PEND_W-1:0]      pend_ff;
   logic        [mrms_pkg::POS_W-1:0]       pos_ff;
   logic                                    done_ff;

   logic signed [mrms_pkg::ACC_W-1:0]       acc_in;
   logic signed [mrms_pkg::ACC_W-1:0]       acc_neg;
   logic        [mrms_pkg::MAG_W-1:0]       mag_in;
   logic        [mrms_pkg::SCALE_W:0]       shifted;
   logic        [mrms_pkg::SCALE_W+1:0]     diff;
   logic                                    qbit;
   logic        [mrms_pkg::SCALE_W-1:0]     prem_in;
   logic signed [mrms_pkg::ACC_W-1:0]       qext;
   logic signed [mrms_pkg::ACC_W-1:0]       q_in;
   logic signed [mrms_pkg::REM_W-1:0]       pext;
   logic signed [mrms_pkg::REM_W-1:0]       rem_in;
   logic signed [mrms_pkg::PEND_W:0]        psum;
   logic signed [mrms_pkg::PEND_W-1:0]      pend_in;
   logic signed [mrms_pkg::POS_W-1:0]       drain;

   // shift-add step: one multiplier bit per cycle
   assign acc_in  = mult_ff[0] ? acc_ff + mcand_ff : acc_ff;
   assign acc_neg = -acc_ff;
   assign mag_in  = acc_ff[mrms_pkg::ACC_W-1] ? acc_neg[mrms_pkg::MAG_W-1:0]
                                               : acc_ff[mrms_pkg::MAG_W-1:0];

   // restoring divide step: one quotient bit per cycle
   assign shifted = {prem_ff, quo_ff[mrms_pkg::MAG_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign qbit    = ~diff[mrms_pkg::SCALE_W+1];
   assign prem_in = qbit ? diff[mrms_pkg::SCALE_W-1:0] : shifted[mrms_pkg::SCALE_W-1:0];

   // signs back on; Y axis adds the negated quotient
   assign qext   = {1'b0, quo_ff};
   assign q_in   = (sign_ff ^ negate) ? -qext : qext;
   assign pext   = {1'b0, prem_ff};
   assign rem_in = sign_ff ? -pext : pext;

   // saturating pending update
   assign psum = {pend_ff[mrms_pkg::PEND_W-1], pend_ff}
               + {{(mrms_pkg::PEND_W + 1 - mrms_pkg::ACC_W){q_ff[mrms_pkg::ACC_W-1]}}, q_ff};
   always_comb begin
      if (psum[mrms_pkg::PEND_W] != psum[mrms_pkg::PEND_W-1]) begin
         pend_in = psum[mrms_pkg::PEND_W] ? mrms_pkg::PEND_MIN : mrms_pkg::PEND_MAX;
      end else begin
         pend_in = psum[mrms_pkg::PEND_W-1:0];
      end
   end

   always_comb begin
      if (pend_ff > mrms_pkg::DRAIN_HI) begin
         drain = mrms_pkg::DRAIN_POS;
      end else if (pend_ff < mrms_pkg::DRAIN_LO) begin
         drain = mrms_pkg::DRAIN_NEG;
      end else begin
         drain = pend_ff[mrms_pkg::POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         pend_ff  <= '0;
         pos_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  acc_ff   <= mrms_pkg::ACC_W'(rem_ff);
                  mcand_ff <= mrms_pkg::ACC_W'(delta);
                  mult_ff  <= scale_num;
                  den_ff   <= (scale_den == '0) ? mrms_pkg::SCALE_W'(1) : scale_den;
                  cnt_ff   <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               acc_ff   <= acc_in;
               mcand_ff <= mcand_ff <<< 1;
               mult_ff  <= mult_ff >> 1;
               if (cnt_ff == mrms_pkg::CNT_W'(mrms_pkg::MUL_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_ABS;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_ABS: begin
               sign_ff  <= acc_ff[mrms_pkg::ACC_W-1];
               quo_ff   <= mag_in;
               prem_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               prem_ff <= prem_in;
               quo_ff  <= {quo_ff[mrms_pkg::MAG_W-2:0], qbit};
               if (cnt_ff == mrms_pkg::CNT_W'(mrms_pkg::DIV_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_SIGN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SIGN: begin
               q_ff     <= q_in;
               rem_ff   <= rem_in;
               state_ff <= ST_PEND;
            end
            ST_PEND: begin
               pend_ff  <= pend_in;
               state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               pos_ff   <= pos_ff + drain[mrms_pkg::POS_W-1:0];
               pend_ff  <= pend_ff - mrms_pkg::PEND_W'(drain);
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign done     = done_ff;
   assign position = pos_ff;

   // partial remainder stays below the divisor throughout the divide
   a_prem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (prem_ff < den_ff))
      else $error("partial remainder not below divisor");

   // zero divisor is mapped to one before the divide starts
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ABS) |-> (den_ff != '0))
      else $error("divisor zero in divide");

   // kept remainder magnitude stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PEND) |-> (prem_ff < den_ff))
      else $error("remainder out of range");

endmodule

// File: rtl/core/mouse_report_motion_scaler_unit.sv
// Mouse report motion scaler. Each request carries one boot-protocol mouse
// report: buttons in tdata[7:0], signed delta_x in [15:8], signed delta_y in
// [23:16]. Buttons become an active-low 5-bit joystick word (left clears bit
// 4, right bit 0, middle bit 1). Each delta is scaled by scale_num/scale_den
// with the fractional remainder carried from report to report, summed into a
// saturating 24-bit pending count (Y negated so up is positive), and at most
// 50 counts per report drain into 7-bit wrapping paddle positions. After a
// request is accepted it passes through the bit-serial shift-add multiplier,
// a magnitude step, the restoring divider (one quotient bit per cycle), then
// sign fixup, pending update, drain and output load. One request is in
// flight at a time; req_tready rises as the result loads into the output
// register, so a new request is taken only after the last result has
// loaded, later while rsp_tready holds off a waiting result. A scale_den of
// zero acts as one. Write the csr port only while no request is in flight.
module mouse_report_motion_scaler_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request: [7:0] buttons, [15:8] delta_x, [23:16] delta_y
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,
   // response: [4:0] joy_lines, [11:5] paddle_x, [18:12] paddle_y, rest zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,
   // configuration writes
   input  logic                              csr_we,
   input  logic [0:0]                        csr_addr,
   input  logic [mrms_pkg::SCALE_W-1:0]      csr_wdata
);

   logic [mrms_pkg::SCALE_W-1:0] num_ff;
   logic [mrms_pkg::SCALE_W-1:0] den_ff;
   logic                         busy_ff;
   logic                         hold_ff;
   logic [mrms_pkg::JOY_W-1:0]   joy_ff;
   logic                         rsp_valid_ff;
   logic [mrms_pkg::JOY_W-1:0]   rsp_joy_ff;
   logic [mrms_pkg::POS_W-1:0]   rsp_x_ff;
   logic [mrms_pkg::POS_W-1:0]   rsp_y_ff;

   logic [mrms_pkg::JOY_W-1:0]   joy_in;
   logic                         req_take;
   logic                         out_free;
   logic                         load;
   logic                         done_x;
   logic                         done_y;
   logic [mrms_pkg::POS_W-1:0]   pos_x;
   logic [mrms_pkg::POS_W-1:0]   pos_y;
   logic [mrms_pkg::BTN_W-1:0]   buttons;
   logic signed [mrms_pkg::DELTA_W-1:0] delta_x;
   logic signed [mrms_pkg::DELTA_W-1:0] delta_y;

   assign buttons = req_tdata[7:0];
   assign delta_x = req_tdata[15:8];
   assign delta_y = req_tdata[23:16];

   assign req_tready = ~busy_ff;
   assign req_take   = req_tvalid & req_tready;

   // output slot free when empty or being drained this cycle
   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign load     = (done_x | hold_ff) & out_free;

   always_comb begin
      joy_in = mrms_pkg::JOY_IDLE;
      if (buttons[0]) joy_in = joy_in & ~mrms_pkg::JOY_LEFT;
      if (buttons[1]) joy_in = joy_in & ~mrms_pkg::JOY_RIGHT;
      if (buttons[2]) joy_in = joy_in & ~mrms_pkg::JOY_MIDDLE;
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= mrms_pkg::SCALE_W'(1);
         den_ff <= mrms_pkg::SCALE_W'(1);
      end else if (csr_we) begin
         unique case (mrms_pkg::csr_index_type'(csr_addr))
            mrms_pkg::CSR_SCALE_NUM: num_ff <= csr_wdata;
            mrms_pkg::CSR_SCALE_DEN: den_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request tracking and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            busy_ff <= 1'b1;
            joy_ff  <= joy_in;
         end else if (load) begin
            busy_ff <= 1'b0;
         end

         if (load) begin
            hold_ff <= 1'b0;
         end else if (done_x) begin
            hold_ff <= 1'b1;   // result done, output still stalled
         end

         if (load) begin
            rsp_valid_ff <= 1'b1;
            rsp_joy_ff   <= joy_ff;
            rsp_x_ff     <= pos_x;
            rsp_y_ff     <= pos_y;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   mrms_axis u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .negate    (1'b0),
      .delta     (delta_x),
      .scale_num (num_ff),
      .scale_den (den_ff),
      .done      (done_x),
      .position  (pos_x)
   );

   mrms_axis u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .negate    (1'b1),
      .delta     (delta_y),
      .scale_num (num_ff),
      .scale_den (den_ff),
      .done      (done_y),
      .position  (pos_y)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_y_ff, rsp_x_ff, rsp_joy_ff};

   // both axes run in lockstep
   a_axes_lockstep: assert property (@(posedge clock) disable iff (reset)
      done_x == done_y)
      else $error("axis units out of step");

   // an axis finishes only for a request in flight
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done_x |-> busy_ff)
      else $error("axis done with no request in flight");

   // a held result implies the output register is still occupied
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> rsp_valid_ff)
      else $error("result held while output register empty");

endmodule
